FILE: sv/msst_pkg.sv
// Shared types and constants for the motor speed step with stall trip block.
package msst_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_LEVEL   = 2'd0,
        CFG_SPEED_LEVEL = 2'd1,
        CFG_TICK_LIMIT  = 2'd2,
        CFG_SPEED_GAIN  = 2'd3
    } t_cfg_idx;

    localparam logic [7:0] COUNT_MAX = 8'd255;
    localparam logic signed [8:0] PWM_POS_MAX = 9'sd255;
    localparam logic signed [8:0] PWM_NEG_MAX = -9'sd255;
    localparam logic signed [15:0] SUM_POS_MAX = 16'sd255;
    localparam logic signed [15:0] SUM_NEG_MAX = -16'sd255;

    typedef struct packed {
        logic [7:0]  stall_pwm_level;
        logic [14:0] stall_speed_level;
        logic [7:0]  stall_tick_limit;
        logic [7:0]  speed_gain;
    } t_cfg;

    typedef struct packed {
        logic               enable_write;
        logic               enable_value;
        logic signed [15:0] target_speed;
        logic signed [15:0] measured_speed;
        logic signed [8:0]  current_pwm;
    } t_step_in;

    typedef struct packed {
        logic signed [8:0] next_pwm;
        logic              enabled_now;
        logic              stall_trip;
    } t_step_out;

endpackage

FILE: sv/msst_in_if.sv
// Input channel interface carrying one control tick word.
interface msst_in_if;
    logic               valid;
    logic               ready;
    logic               enable_write;
    logic               enable_value;
    logic signed [15:0] target_speed;
    logic signed [15:0] measured_speed;
    logic signed [8:0]  current_pwm;

    modport source (
        output valid, enable_write, enable_value, target_speed, measured_speed, current_pwm,
        input  ready
    );
    modport sink (
        input  valid, enable_write, enable_value, target_speed, measured_speed, current_pwm,
        output ready
    );
endinterface

FILE: sv/msst_out_if.sv
// Output channel interface carrying one result word.
interface msst_out_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] next_pwm;
    logic              enabled_now;
    logic              stall_trip;

    modport source (
        output valid, next_pwm, enabled_now, stall_trip,
        input  ready
    );
    modport sink (
        input  valid, next_pwm, enabled_now, stall_trip,
        output ready
    );
endinterface

FILE: sv/msst_step.sv
// Combinational step logic: stall detection, trip counter and PWM update.
module msst_step (
    input  msst_pkg::t_cfg      i_cfg,
    input  msst_pkg::t_step_in  i_step,
    input  logic                i_enable_flag,
    input  logic [7:0]          i_stall_count,
    output msst_pkg::t_step_out o_result,
    output logic [7:0]          o_stall_count
);

    logic               en_in;
    logic signed [9:0]  pwm10;
    logic signed [9:0]  thp10;
    logic signed [16:0] spd17;
    logic signed [16:0] ths17;
    logic               stall;
    logic [7:0]         cnt_inc;
    logic               trip;
    logic               stop;
    logic [15:0]        err16;
    logic [15:0]        prod;
    logic signed [15:0] sum;
    logic signed [8:0]  clamped;
    logic signed [8:0]  shaped;

    always_comb begin
        en_in = i_step.enable_write ? i_step.enable_value : i_enable_flag;
        pwm10 = {i_step.current_pwm[8], i_step.current_pwm};
        thp10 = {2'b00, i_cfg.stall_pwm_level};
        spd17 = {i_step.measured_speed[15], i_step.measured_speed};
        ths17 = {2'b00, i_cfg.stall_speed_level};
        stall = ((pwm10 > thp10) && (spd17 < ths17))
             || ((pwm10 < -thp10) && (spd17 > -ths17));

        cnt_inc = (i_stall_count != msst_pkg::COUNT_MAX) ? i_stall_count + 8'd1
                                                         : i_stall_count;
        trip = 1'b0;
        o_stall_count = i_stall_count;
        if (en_in) begin
            if (stall) begin
                trip = (cnt_inc >= i_cfg.stall_tick_limit);
                o_stall_count = trip ? 8'd0 : cnt_inc;
            end else begin
                o_stall_count = 8'd0;
            end
        end

        stop = (i_step.target_speed == 16'sd0)
            || ((i_step.target_speed > 16'sd0) && (i_step.measured_speed < 16'sd0))
            || ((i_step.target_speed < 16'sd0) && (i_step.measured_speed > 16'sd0));

        err16 = 16'(unsigned'(i_step.target_speed) - unsigned'(i_step.measured_speed));
        prod = err16 * {8'd0, i_cfg.speed_gain};
        sum = signed'(16'({{7{i_step.current_pwm[8]}}, i_step.current_pwm} + prod));

        if (sum > msst_pkg::SUM_POS_MAX) begin
            clamped = msst_pkg::PWM_POS_MAX;
        end else if (sum < msst_pkg::SUM_NEG_MAX) begin
            clamped = msst_pkg::PWM_NEG_MAX;
        end else begin
            clamped = sum[8:0];
        end

        if (((clamped > 9'sd0) && (i_step.measured_speed < 16'sd0))
            || ((clamped < 9'sd0) && (i_step.measured_speed > 16'sd0))) begin
            shaped = 9'sd0;
        end else begin
            shaped = clamped;
        end

        o_result.next_pwm = (en_in && !trip && !stop) ? shaped : 9'sd0;
        o_result.enabled_now = en_in && !trip;
        o_result.stall_trip = trip;
    end

endmodule

FILE: sv/motor_speed_step_with_stall_trip.sv
// Top level of the motor speed step with stall trip block.
//
//   channel  | direction | word
//   ---------+-----------+---------------------------------------------------------
//   i_in     | sink      | enable_write, enable_value, target_speed, measured_speed,
//            |           | current_pwm
//   o_out    | source    | next_pwm, enabled_now, stall_trip
//   i_cfg_*  | write     | register index and data, no handshake
//
// Each word passes through the input register and then the result register, with one
// word accepted every cycle while the output is not stalled.
// The state update is done as a word moves from the input register to the result
// register, so the following word sees it.
// Synchronous active-low reset clears the valid flags, the enable flag, the stall
// count and the configuration registers.
// A stall on the output holds both stages and drops ready once both are full.
module motor_speed_step_with_stall_trip (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [msst_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [msst_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    msst_in_if.sink                           i_in,
    msst_out_if.source                        o_out
);

    msst_pkg::t_cfg      r_cfg;
    logic                r_in_valid;
    msst_pkg::t_step_in  r_in;
    logic                r_out_valid;
    msst_pkg::t_step_out r_out;
    logic                r_enable_flag;
    logic [7:0]          r_stall_count;

    msst_pkg::t_step_out n_out;
    logic [7:0]          n_stall_count;
    logic                advance;

    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    msst_step u_step (
        .i_cfg         (r_cfg),
        .i_step        (r_in),
        .i_enable_flag (r_enable_flag),
        .i_stall_count (r_stall_count),
        .o_result      (n_out),
        .o_stall_count (n_stall_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (msst_pkg::t_cfg_idx'(i_cfg_idx))
                msst_pkg::CFG_PWM_LEVEL:   r_cfg.stall_pwm_level <= i_cfg_data[7:0];
                msst_pkg::CFG_SPEED_LEVEL: r_cfg.stall_speed_level <= i_cfg_data;
                msst_pkg::CFG_TICK_LIMIT:  r_cfg.stall_tick_limit <= i_cfg_data[7:0];
                msst_pkg::CFG_SPEED_GAIN:  r_cfg.speed_gain <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in.enable_write   <= i_in.enable_write;
            r_in.enable_value   <= i_in.enable_value;
            r_in.target_speed   <= i_in.target_speed;
            r_in.measured_speed <= i_in.measured_speed;
            r_in.current_pwm    <= i_in.current_pwm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_enable_flag <= 1'b0;
            r_stall_count <= 8'd0;
        end else begin
            if (advance) begin
                r_out_valid   <= 1'b1;
                r_enable_flag <= n_out.enabled_now;
                r_stall_count <= n_stall_count;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.next_pwm    = r_out.next_pwm;
    assign o_out.enabled_now = r_out.enabled_now;
    assign o_out.stall_trip  = r_out.stall_trip;

endmodule
